[design/pnf_pkg.sv]
`default_nettype none
package pnf_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int MAX_CHANNELS   = 4;
	localparam int NCH            = 4;
	localparam int OFF_W          = 26;
	localparam int MID_DEPTH      = 4;
	localparam int OUT_DEPTH      = 16;

	localparam logic [3:0] REG_COEF0    = 4'd0;
	localparam logic [3:0] REG_COEF1    = 4'd1;
	localparam logic [3:0] REG_COEF2    = 4'd2;
	localparam logic [3:0] REG_COEF3    = 4'd3;
	localparam logic [3:0] REG_CHANNELS = 4'd4;
	localparam logic [3:0] REG_WIDTH    = 4'd5;
	localparam logic [3:0] REG_HEIGHT   = 4'd6;
	localparam logic [3:0] REG_FORMAT   = 4'd7;

	localparam logic [63:0] COEF_RESET  = 64'h3F80_0000_0000_0000;
	localparam logic [31:0] QNAN        = 32'h7FC0_0000;
	localparam logic [30:0] HALF_MAX_F  = 31'h477F_E000;
	localparam logic [15:0] HALF_SIGN   = 16'h8000;
	localparam logic [15:0] HALF_INF    = 16'h7C00;
	localparam logic [7:0]  HALF_REBIAS = 8'd112;
	localparam logic [4:0]  HALF_EXP_MAX = 5'h1F;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [1:0]       ch;
		logic             lp;
		logic             lf;
	} meta_t;

	typedef struct packed {
		logic [NCH-1:0][7:0] samples;
		logic [OFF_W-1:0]    pix;
		logic                fe;
	} pix_t;

	typedef struct packed {
		logic [NCH-1:0][63:0] coef;
		logic [2:0]           chans;
		logic                 half;
		logic                 planar;
		logic [OFF_W-1:0]     plane;
	} cfg_t;

	typedef struct packed {
		meta_t       meta;
		logic [31:0] value;
	} res_t;

	typedef struct packed {
		logic               sign;
		logic               zero;
		logic               nan;
		logic               inf;
		logic [31:0]        mag;
		logic signed [10:0] e;
	} rnd_t;

	typedef struct packed {
		logic               sign;
		logic               zero;
		logic               nan;
		logic               inf;
		logic [31:0]        m;
		logic signed [10:0] be;
	} nrm_t;

	function automatic logic [31:0] clamp_dim(input logic [12:0] v, input int hi);
		logic [31:0] r;
		r = {19'd0, v};
		if (v == 13'd0)
			r = 32'd1;
		else if (int'(r) > hi)
			r = 32'(hi);
		return r;
	endfunction

	function automatic logic [4:0] lzc32(input logic [31:0] x);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i])
				n = 5'(31 - i);
		end
		return n;
	endfunction

	function automatic nrm_t fp_norm(input rnd_t r, input logic [4:0] lz);
		nrm_t n;
		n.sign = r.sign;
		n.zero = r.zero;
		n.nan  = r.nan;
		n.inf  = r.inf;
		n.m    = r.mag << lz;
		n.be   = r.e + 11'sd158 - $signed({6'd0, lz});
		return n;
	endfunction

	function automatic logic [31:0] fp_pack(input nrm_t n);
		logic [4:0]         d;
		logic [31:0]        sh;
		logic [31:0]        lost;
		logic [23:0]        kept;
		logic               g;
		logic               st;
		logic               inc;
		logic [30:0]        body;
		logic signed [10:0] dd;
		logic [31:0]        r;
		d    = 5'd0;
		dd   = 11'sd1 - n.be;
		sh   = n.m;
		lost = 32'd0;
		if (n.be < 11'sd1) begin
			d    = (dd > 11'sd31) ? 5'd31 : dd[4:0];
			sh   = n.m >> d;
			lost = n.m & ((32'd1 << d) - 32'd1);
		end
		kept = sh[31:8];
		g    = sh[7];
		st   = (|sh[6:0]) | (|lost);
		inc  = g & (st | kept[0]);
		body = (n.be >= 11'sd1) ? {n.be[7:0], kept[22:0]} : {8'd0, kept[22:0]};
		body = body + {30'd0, inc};
		if (n.nan)
			r = QNAN;
		else if (n.inf)
			r = {n.sign, 8'hFF, 23'd0};
		else if (n.zero)
			r = {n.sign, 31'd0};
		else if (n.be >= 11'sd255)
			r = {n.sign, 8'hFF, 23'd0};
		else
			r = {n.sign, body};
		return r;
	endfunction

	function automatic logic [15:0] fp_to_half(input logic [31:0] b);
		logic [31:0] c;
		logic [7:0]  ex;
		logic [15:0] s;
		logic [15:0] h;
		if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
			h = HALF_INF;
		end else begin
			c  = (b[30:0] > HALF_MAX_F) ? {b[31], HALF_MAX_F} : b;
			ex = c[30:23];
			s  = c[31] ? HALF_SIGN : 16'd0;
			if (ex <= HALF_REBIAS)
				h = s;
			else if (ex >= HALF_REBIAS + {3'd0, HALF_EXP_MAX})
				h = s | HALF_INF;
			else
				h = s | {1'b0, 5'(ex - HALF_REBIAS), c[22:13]};
		end
		return h;
	endfunction

endpackage
`default_nettype wire

[design/pixel_normalize_fp16_layout.sv]
`default_nettype none
// Pixel normalizer: one pixel in per push, one result per active channel out,
// each sample scaled and shifted in fp32, optionally narrowed to half, and
// written with its interleaved or planar element offset. The fp pipeline
// takes one channel per cycle while the result queue has room, so a pixel
// with C active channels (1 to 4) is issued channel by channel, and results
// leave at one per cycle while pop is held. A four-entry pixel queue sits
// between the position counters and the arithmetic, and a sixteen-entry
// result queue absorbs pop stalls. No clearing pass after reset. Write
// configuration only while no pixel or result is in flight.
module pixel_normalize_fp16_layout import pnf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  sample_0,
	input  wire logic [7:0]  sample_1,
	input  wire logic [7:0]  sample_2,
	input  wire logic [7:0]  sample_3,
	output logic             empty,
	input  wire logic        pop,
	output logic [25:0]      element_offset,
	output logic [31:0]      value_bits,
	output logic [1:0]       channel_index,
	output logic             last_of_pixel,
	output logic             last_of_frame,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [NCH-1:0][63:0] coef_q;
	logic [2:0]           chans_q;
	logic [WW-1:0]        w_q;
	logic [HW-1:0]        h_q;
	logic [1:0]           fmt_q;
	logic [OFF_W-1:0]     plane_q;
	logic [WW+HW-1:0]     plane_full;
	cfg_t                 cfg;
	logic [NCH-1:0][7:0]  samples;

	logic mid_full, mid_wr, mid_empty, mid_pop;
	pix_t mid_wdata, mid_rdata;
	logic out_wr, out_full, out_pop;
	res_t out_wdata, out_rdata;

	assign cfg_ready  = 1'b1;
	assign samples    = {sample_3, sample_2, sample_1, sample_0};
	assign plane_full = {{HW{1'b0}}, w_q} * {{WW{1'b0}}, h_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= {NCH{COEF_RESET}};
			chans_q <= 3'd3;
			w_q     <= WW'(640);
			h_q     <= HW'(640);
			fmt_q   <= 2'd0;
			plane_q <= OFF_W'(640 * 640);
		end else begin
			plane_q <= OFF_W'(plane_full);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index) inside
					REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3:
						coef_q[cfg_index[1:0]] <= cfg_data;
					REG_CHANNELS:
						chans_q <= 3'(clamp_dim({10'd0, cfg_data[2:0]}, MAX_CHANNELS));
					REG_WIDTH:
						w_q <= WW'(clamp_dim(cfg_data[12:0], MAX_WIDTH));
					REG_HEIGHT:
						h_q <= HW'(clamp_dim(cfg_data[12:0], MAX_HEIGHT));
					REG_FORMAT:
						fmt_q <= cfg_data[1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		cfg.coef   = coef_q;
		cfg.chans  = chans_q;
		cfg.half   = fmt_q[0];
		cfg.planar = fmt_q[1];
		cfg.plane  = plane_q;
	end

	pnf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.samples  (samples),
		.w        (w_q),
		.h        (h_q),
		.mid_full (mid_full),
		.full     (full),
		.mid_wr   (mid_wr),
		.mid_item (mid_wdata)
	);

	pnf_fifo #(
		.W     ($bits(pix_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.full    (mid_full),
		.empty   (mid_empty)
	);

	pnf_back #(
		.DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_empty (mid_empty),
		.mid_item  (mid_rdata),
		.out_pop   (out_pop),
		.mid_pop   (mid_pop),
		.out_wr    (out_wr),
		.out_item  (out_wdata)
	);

	assign out_pop = pop && !empty;

	pnf_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data (out_wdata),
		.rd_en   (out_pop),
		.rd_data (out_rdata),
		.full    (out_full),
		.empty   (empty)
	);

	assign element_offset = out_rdata.meta.off;
	assign value_bits     = out_full ? out_rdata.value : out_rdata.value;
	assign channel_index  = out_rdata.meta.ch;
	assign last_of_pixel  = out_rdata.meta.lp;
	assign last_of_frame  = out_rdata.meta.lf;
endmodule
`default_nettype wire

[design/pnf_fifo.sv]
`default_nettype none
module pnf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	input  wire logic         rd_en,
	output logic      [W-1:0] rd_data,
	output logic              full,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (!wr_en && rd_en)
				count_q <= count_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

[design/pnf_front.sv]
`default_nettype none
module pnf_front import pnf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire logic [NCH-1:0][7:0] samples,
	input  wire logic [WW-1:0]       w,
	input  wire logic [HW-1:0]       h,
	input  wire logic                mid_full,
	output logic                     full,
	output logic                     mid_wr,
	output pix_t                     mid_item
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [CW:0]        col_nx;
	logic [RW:0]        row_nx;
	logic               row_end;
	logic               frame_end;
	logic               acc;
	logic [RW+WW:0]     pix_full;

	assign full      = mid_full;
	assign acc       = push && !mid_full;
	assign mid_wr    = acc;
	assign col_nx    = {1'b0, col_q} + 1'b1;
	assign row_nx    = {1'b0, row_q} + 1'b1;
	assign row_end   = 32'(col_nx) >= 32'(w);
	assign frame_end = row_end && (32'(row_nx) >= 32'(h));
	assign pix_full  = ({{(WW+1){1'b0}}, row_q} * {{(RW+1){1'b0}}, w})
	                 + (RW+WW+1)'(col_q);

	always_comb begin
		mid_item.samples = samples;
		mid_item.pix     = OFF_W'(pix_full);
		mid_item.fe      = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_nx[RW-1:0];
			end else begin
				col_q <= col_nx[CW-1:0];
			end
		end
	end
endmodule
`default_nettype wire

[design/pnf_back.sv]
`default_nettype none
module pnf_back import pnf_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  wire logic mid_empty,
	input  pix_t      mid_item,
	input  wire logic out_pop,
	output logic      mid_pop,
	output logic      out_wr,
	output res_t      out_item
);
	localparam int PW  = $clog2(DEPTH + 1);
	localparam int NST = 11;

	logic [1:0]    ch_q;
	logic [PW-1:0] pending_q;
	logic [NST:1]  vld_q;
	logic          issue;
	logic          last;
	logic [27:0]   ch_plane;
	logic [28:0]   pix_ch;
	meta_t         meta_in;

	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	meta_t meta_s7, meta_s8, meta_s9, meta_s10;
	logic [7:0]  sample_s1;
	logic [31:0] scale_s1, shift_s1, shift_s2, shift_s3, shift_s4, shift_s5;
	rnd_t        prod_s2, prod_s3, sum_s7, sum_s8;
	logic [4:0]  lz_s3, lz_s8;
	nrm_t        pn_s4, sn_s9;
	logic [31:0] pb_s5, sb_s10;
	logic [26:0] mbig_s6, msml_s6;
	logic        sub_s6, bsign_s6, zsign_s6, nan_s6, inf_s6, isign_s6;
	logic [7:0]  ebig_s6;
	res_t        out_s11;

	rnd_t        prod_c;
	rnd_t        sum_c;
	logic [26:0] mbig_c, msml_c;
	logic        sub_c, bsign_c, zsign_c, nan_c, inf_c, isign_c;
	logic [7:0]  ebig_c;

	assign last     = ({1'b0, ch_q} + 3'd1) == cfg.chans;
	assign issue    = !mid_empty && (pending_q < PW'(DEPTH));
	assign mid_pop  = issue && last;
	assign ch_plane = {26'd0, ch_q} * {2'd0, cfg.plane};
	assign pix_ch   = {3'd0, mid_item.pix} * {26'd0, cfg.chans};

	always_comb begin
		meta_in.off = cfg.planar ? ch_plane[OFF_W-1:0] + mid_item.pix
		                         : pix_ch[OFF_W-1:0] + OFF_W'(ch_q);
		meta_in.ch  = ch_q;
		meta_in.lp  = last;
		meta_in.lf  = last && mid_item.fe;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q      <= '0;
			pending_q <= '0;
			vld_q     <= '0;
		end else begin
			if (issue)
				ch_q <= last ? 2'd0 : ch_q + 2'd1;
			if (issue && !out_pop)
				pending_q <= pending_q + 1'b1;
			else if (!issue && out_pop)
				pending_q <= pending_q - 1'b1;
			vld_q <= {vld_q[NST-1:1], issue};
		end
	end

	// product of the sample and the channel scale
	always_comb begin
		logic [7:0]  es;
		logic [23:0] sig;
		logic [7:0]  eeff;
		es          = scale_s1[30:23];
		sig         = {es != 8'd0, scale_s1[22:0]};
		eeff        = (es == 8'd0) ? 8'd1 : es;
		prod_c.sign = scale_s1[31];
		prod_c.nan  = (es == 8'hFF) && (scale_s1[22:0] != 23'd0 || sample_s1 == 8'd0);
		prod_c.inf  = (es == 8'hFF) && scale_s1[22:0] == 23'd0 && sample_s1 != 8'd0;
		prod_c.zero = sample_s1 == 8'd0 || sig == 24'd0;
		prod_c.mag  = {24'd0, sample_s1} * {8'd0, sig};
		prod_c.e    = $signed({3'd0, eeff}) - 11'sd150;
	end

	// operand alignment for the shift add
	always_comb begin
		logic [7:0]  ea, eb, ebs;
		logic [23:0] ma, mb, mbs;
		logic        sa, sb, swap, a_nan, b_nan, a_inf, b_inf;
		logic [7:0]  diff;
		logic [4:0]  d;
		logic [26:0] sm, smsh, smlost;
		ea     = (pb_s5[30:23] == 8'd0) ? 8'd1 : pb_s5[30:23];
		eb     = (shift_s5[30:23] == 8'd0) ? 8'd1 : shift_s5[30:23];
		ma     = {pb_s5[30:23] != 8'd0, pb_s5[22:0]};
		mb     = {shift_s5[30:23] != 8'd0, shift_s5[22:0]};
		sa     = pb_s5[31];
		sb     = shift_s5[31];
		a_nan  = pb_s5[30:23] == 8'hFF && pb_s5[22:0] != 23'd0;
		b_nan  = shift_s5[30:23] == 8'hFF && shift_s5[22:0] != 23'd0;
		a_inf  = pb_s5[30:23] == 8'hFF && pb_s5[22:0] == 23'd0;
		b_inf  = shift_s5[30:23] == 8'hFF && shift_s5[22:0] == 23'd0;
		swap   = shift_s5[30:0] > pb_s5[30:0];
		ebig_c = swap ? eb : ea;
		ebs    = swap ? ea : eb;
		mbs    = swap ? ma : mb;
		bsign_c = swap ? sb : sa;
		diff   = ebig_c - ebs;
		d      = (diff > 8'd31) ? 5'd31 : diff[4:0];
		sm     = {mbs, 3'd0};
		smsh   = sm >> d;
		smlost = sm & ((27'd1 << d) - 27'd1);
		mbig_c = {swap ? mb : ma, 3'd0};
		msml_c = {smsh[26:1], smsh[0] | (|smlost)};
		sub_c  = sa ^ sb;
		zsign_c = sa & sb;
		nan_c  = a_nan || b_nan || (a_inf && b_inf && sa != sb);
		inf_c  = (a_inf || b_inf) && !nan_c;
		isign_c = a_inf ? sa : sb;
	end

	// magnitude add or subtract
	always_comb begin
		logic [27:0] s28;
		s28 = sub_s6 ? {1'b0, mbig_s6} - {1'b0, msml_s6}
		             : {1'b0, mbig_s6} + {1'b0, msml_s6};
		sum_c.nan  = nan_s6;
		sum_c.inf  = inf_s6;
		sum_c.zero = s28 == 28'd0;
		sum_c.mag  = {4'd0, s28};
		sum_c.e    = $signed({3'd0, ebig_s6}) - 11'sd153;
		if (inf_s6)
			sum_c.sign = isign_s6;
		else if (s28 == 28'd0)
			sum_c.sign = zsign_s6;
		else
			sum_c.sign = bsign_s6;
	end

	always_ff @(posedge clk) begin
		meta_s1   <= meta_in;
		sample_s1 <= mid_item.samples[ch_q];
		scale_s1  <= cfg.coef[ch_q][63:32];
		shift_s1  <= cfg.coef[ch_q][31:0];

		meta_s2  <= meta_s1;
		prod_s2  <= prod_c;
		shift_s2 <= shift_s1;

		meta_s3  <= meta_s2;
		prod_s3  <= prod_s2;
		lz_s3    <= lzc32(prod_s2.mag);
		shift_s3 <= shift_s2;

		meta_s4  <= meta_s3;
		pn_s4    <= fp_norm(prod_s3, lz_s3);
		shift_s4 <= shift_s3;

		meta_s5  <= meta_s4;
		pb_s5    <= fp_pack(pn_s4);
		shift_s5 <= shift_s4;

		meta_s6  <= meta_s5;
		mbig_s6  <= mbig_c;
		msml_s6  <= msml_c;
		sub_s6   <= sub_c;
		bsign_s6 <= bsign_c;
		zsign_s6 <= zsign_c;
		ebig_s6  <= ebig_c;
		nan_s6   <= nan_c;
		inf_s6   <= inf_c;
		isign_s6 <= isign_c;

		meta_s7 <= meta_s6;
		sum_s7  <= sum_c;

		meta_s8 <= meta_s7;
		sum_s8  <= sum_s7;
		lz_s8   <= lzc32(sum_s7.mag);

		meta_s9 <= meta_s8;
		sn_s9   <= fp_norm(sum_s8, lz_s8);

		meta_s10 <= meta_s9;
		sb_s10   <= fp_pack(sn_s9);

		out_s11.meta  <= meta_s10;
		out_s11.value <= cfg.half ? {16'd0, fp_to_half(sb_s10)} : sb_s10;
	end

	assign out_wr   = vld_q[NST];
	assign out_item = out_s11;
endmodule
`default_nettype wire

[verif/pixel_normalize_fp16_layout_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module pixel_normalize_fp16_layout_tb;
	import pnf_pkg::*;

	localparam logic [3:0] REG_NONE = 4'hF;

	typedef struct packed {
		logic [25:0] off;
		logic [31:0] value;
		logic [1:0]  ch;
		logic        lp;
		logic        lf;
	} norm_result_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  sample_0;
	logic [7:0]  sample_1;
	logic [7:0]  sample_2;
	logic [7:0]  sample_3;
	logic        empty;
	logic        pop;
	logic [25:0] element_offset;
	logic [31:0] value_bits;
	logic [1:0]  channel_index;
	logic        last_of_pixel;
	logic        last_of_frame;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [63:0] cfg_data;

	norm_result_t pending_results[$];
	logic [63:0]  coef_m[4];
	logic [2:0]   chans_m;
	logic [12:0]  width_m;
	logic [12:0]  height_m;
	logic [1:0]   format_m;
	logic [31:0]  col_m;
	logic [31:0]  row_m;

	int mismatches;
	int results_seen;
	int pixels_sent;
	int regs_written;
	int pop_hold;
	int pop_wait;
	bit no_idle;

	pixel_normalize_fp16_layout u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.sample_0(sample_0), .sample_1(sample_1), .sample_2(sample_2), .sample_3(sample_3),
		.empty(empty), .pop(pop), .element_offset(element_offset), .value_bits(value_bits),
		.channel_index(channel_index), .last_of_pixel(last_of_pixel),
		.last_of_frame(last_of_frame), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// round an exact value sgn * m * 2^e to fp32, nearest even
	function automatic logic [31:0] fp32_round(input logic sgn, input logic [79:0] m, input int e);
		int p;
		int lsb;
		int drop;
		logic [79:0] kept;
		logic g;
		logic st;
		if (m == 80'd0)
			return {sgn, 31'd0};
		p = 0;
		for (int i = 0; i < 80; i++)
			if (m[i])
				p = i;
		lsb = p - 23 + e;
		if (lsb < -149)
			lsb = -149;
		drop = lsb - e;
		if (drop > 0) begin
			if (drop >= 80) begin
				kept = 80'd0;
				g = 1'b0;
				st = 1'b1;
			end else begin
				kept = m >> drop;
				g = m[drop-1];
				st = |(m & ((80'd1 << (drop - 1)) - 80'd1));
			end
			if (g && (st || kept[0]))
				kept = kept + 80'd1;
		end else begin
			kept = m << (-drop);
		end
		if (kept[24]) begin
			kept = kept >> 1;
			lsb++;
		end
		if (kept[23]) begin
			if (lsb + 150 >= 255)
				return {sgn, 8'hFF, 23'd0};
			return {sgn, 8'(lsb + 150), kept[22:0]};
		end
		return {sgn, 8'd0, kept[22:0]};
	endfunction

	function automatic logic [23:0] fp32_mant(input logic [31:0] b, output int e);
		if (b[30:23] == 8'd0) begin
			e = -149;
			return {1'b0, b[22:0]};
		end
		e = int'(b[30:23]) - 150;
		return {1'b1, b[22:0]};
	endfunction

	function automatic logic [31:0] fp32_mul_byte(input logic [7:0] s, input logic [31:0] b);
		int e;
		logic [23:0] m;
		if (b[30:23] == 8'hFF) begin
			if (b[22:0] != 23'd0 || s == 8'd0)
				return QNAN;
			return {b[31], 8'hFF, 23'd0};
		end
		if (s == 8'd0 || b[30:0] == 31'd0)
			return {b[31], 31'd0};
		m = fp32_mant(b, e);
		return fp32_round(b[31], 80'(s) * 80'(m), e);
	endfunction

	function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
		int ea;
		int eb;
		int d;
		logic [79:0] wa;
		logic [79:0] wb;
		logic [79:0] sum;
		logic [31:0] t;
		logic sg;
		if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0))
			return QNAN;
		if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000 && a[31] != b[31])
			return QNAN;
		if (a[30:23] == 8'hFF)
			return a;
		if (b[30:23] == 8'hFF)
			return b;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return {a[31] & b[31], 31'd0};
		if (a[30:0] == 31'd0)
			return b;
		if (b[30:0] == 31'd0)
			return a;
		if (b[30:0] > a[30:0]) begin
			t = a;
			a = b;
			b = t;
		end
		wa = 80'(fp32_mant(a, ea));
		wb = 80'(fp32_mant(b, eb));
		d = ea - eb;
		// far below the rounding point: keep only a sticky
		if (d > 40) begin
			wb = 80'd1;
			eb = ea - 40;
			d = 40;
		end
		wa = wa << d;
		if (a[31] == b[31]) begin
			sum = wa + wb;
			sg = a[31];
		end else if (wa >= wb) begin
			sum = wa - wb;
			sg = a[31];
		end else begin
			sum = wb - wa;
			sg = b[31];
		end
		if (sum == 80'd0)
			return 32'd0;
		return fp32_round(sg, sum, eb);
	endfunction

	function automatic logic [31:0] scaled_sample(input logic [7:0] s, input logic [63:0] coef,
			input logic half);
		logic [31:0] b;
		logic [15:0] h;
		int e;
		b = fp32_add(fp32_mul_byte(s, coef[63:32]), coef[31:0]);
		if (b[30:23] == 8'hFF && b[22:0] != 23'd0)
			b = QNAN;
		if (!half)
			return b;
		if (!(b[30:23] == 8'hFF && b[22:0] != 23'd0) && b[30:0] > HALF_MAX_F)
			b = {b[31], HALF_MAX_F};
		e = int'(b[30:23]) - 112;
		h = b[31] ? HALF_SIGN : 16'd0;
		if (e >= 31)
			h = h | HALF_INF;
		else if (e > 0)
			h = h | {1'b0, 5'(e), b[22:13]};
		return {16'd0, h};
	endfunction

	task automatic predict_pixel(input logic [7:0] s[4]);
		int chans;
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] pix;
		logic [31:0] off;
		logic row_end;
		logic frame_end;
		norm_result_t r;
		chans = (chans_m == 3'd0) ? 1 : (chans_m > 3'd4) ? 4 : int'(chans_m);
		w = (width_m == 13'd0) ? 32'd1 : (width_m > 13'd4096) ? 32'd4096 : 32'(width_m);
		h = (height_m == 13'd0) ? 32'd1 : (height_m > 13'd4096) ? 32'd4096 : 32'(height_m);
		row_end = (col_m + 32'd1 >= w);
		frame_end = row_end && (row_m + 32'd1 >= h);
		pix = row_m * w + col_m;
		for (int c = 0; c < chans; c++) begin
			off = format_m[1] ? 32'(c) * (w * h) + pix : pix * 32'(chans) + 32'(c);
			r.off = off[25:0];
			r.value = scaled_sample(s[c], coef_m[c], format_m[0]);
			r.ch = 2'(c);
			r.lp = (c + 1 == chans);
			r.lf = (c + 1 == chans) && frame_end;
			pending_results.push_back(r);
		end
		if (row_end) begin
			col_m = 32'd0;
			row_m = frame_end ? 32'd0 : row_m + 32'd1;
		end else begin
			col_m = col_m + 32'd1;
		end
	endtask

	task automatic send_pixel(input logic [7:0] s0, input logic [7:0] s1,
			input logic [7:0] s2, input logic [7:0] s3);
		int g;
		logic [7:0] s[4];
		g = no_idle ? 0 : rand_gap();
		s = '{s0, s1, s2, s3};
		@(negedge clk);
		if (g > 0) begin
			push = 1'b0;
			repeat (g) @(negedge clk);
		end
		push = 1'b1;
		sample_0 = s0;
		sample_1 = s1;
		sample_2 = s2;
		sample_3 = s3;
		do @(posedge clk); while (full);
		predict_pixel(s);
		pixels_sent++;
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		wait (pending_results.size() == 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3: coef_m[idx[1:0]] = data;
			REG_CHANNELS: chans_m = data[2:0];
			REG_WIDTH:    width_m = data[12:0];
			REG_HEIGHT:   height_m = data[12:0];
			REG_FORMAT:   format_m = data[1:0];
			default: ;
		endcase
		regs_written++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_fp32();
		int k;
		logic [31:0] sp[7];
		sp = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
			32'h0000_0001, 32'h7F7F_FFFF};
		k = $urandom_range(0, 9);
		if (k == 0)
			return $urandom;
		if (k == 1)
			return sp[$urandom_range(0, 6)];
		return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
	endfunction

	function automatic logic [63:0] rand_dim();
		if ($urandom_range(0, 9) < 8)
			return 64'($urandom_range(1, 6));
		return {$urandom, $urandom};
	endfunction

	// check each popped result against the oldest prediction
	initial begin
		norm_result_t got;
		norm_result_t want;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (pop_hold > 0) begin
				pop = 1'b0;
				pop_hold--;
			end else if (pop_wait > 0) begin
				pop = 1'b0;
				pop_wait--;
			end else begin
				pop = 1'b1;
			end
			@(posedge clk);
			if (pop && !empty && arst_n) begin
				got = '{element_offset, value_bits, channel_index, last_of_pixel, last_of_frame};
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: off=%h val=%h ch=%0d lp=%b lf=%b",
							got.off, got.value, got.ch, got.lp, got.lf);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp off=%h val=%h ch=%0d lp=%b lf=%b",
								" | got off=%h val=%h ch=%0d lp=%b lf=%b"},
								want.off, want.value, want.ch, want.lp, want.lf,
								got.off, got.value, got.ch, got.lp, got.lf);
					end
				end
				pop_wait = no_idle ? 0 : rand_gap();
			end
		end
	end

	task automatic test_reset_defaults();
		send_pixel(8'h00, 8'hFF, 8'h80, 8'h55);
		send_pixel(8'hFF, 8'h00, 8'h01, 8'hAA);
		send_pixel(8'h7F, 8'hFE, 8'h00, 8'hFF);
		drain();
	endtask

	task automatic test_fp32_specials();
		write_reg(REG_CHANNELS, 64'd4);
		write_reg(REG_WIDTH, 64'd3);
		write_reg(REG_HEIGHT, 64'd2);
		write_reg(REG_FORMAT, 64'd0);
		write_reg(REG_COEF0, {32'h7FC0_0001, 32'h0});
		write_reg(REG_COEF1, {32'h7F80_0000, 32'h3F80_0000});
		write_reg(REG_COEF2, {32'h7F7F_FFFF, 32'h7F7F_FFFF});
		write_reg(REG_COEF3, {32'h0000_0001, 32'h8000_0000});
		send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h01, 8'h80, 8'h01, 8'h80);
		drain();
		write_reg(REG_COEF1, {32'hFF80_0000, 32'h7F80_0000});
		send_pixel(8'h02, 8'h03, 8'h7F, 8'h00);
		drain();
	endtask

	task automatic test_half_planar();
		write_reg(REG_FORMAT, 64'd3);
		write_reg(REG_COEF0, {32'h3F80_0000, 32'h477F_E000});
		write_reg(REG_COEF1, {32'hC700_0000, 32'h0});
		write_reg(REG_COEF2, {32'hB380_0000, 32'h0});
		write_reg(REG_COEF3, {32'h7FC0_0000, 32'h0});
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h01, 8'h00, 8'h00);
		send_pixel(8'h10, 8'h80, 8'h01, 8'h40);
		drain();
		write_reg(REG_FORMAT, 64'd1);
		send_pixel(8'hFE, 8'h02, 8'h08, 8'h01);
		drain();
	endtask

	task automatic test_size_clamps();
		write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_CHANNELS, 64'd0);
		write_reg(REG_WIDTH, 64'd0);
		write_reg(REG_HEIGHT, 64'd0);
		write_reg(REG_FORMAT, 64'd2);
		send_pixel(8'h11, 8'h22, 8'h33, 8'h44);
		send_pixel(8'hEE, 8'hDD, 8'hCC, 8'hBB);
		drain();
		write_reg(REG_CHANNELS, 64'd7);
		write_reg(REG_WIDTH, 64'h1FFF);
		write_reg(REG_HEIGHT, 64'h1FFF);
		write_reg(REG_FORMAT, 64'd2);
		send_pixel(8'h01, 8'h02, 8'h03, 8'h04);
		send_pixel(8'hF0, 8'h0F, 8'hA5, 8'h5A);
		drain();
	endtask

	task automatic test_shrunk_frame();
		write_reg(REG_CHANNELS, 64'd2);
		write_reg(REG_WIDTH, 64'd5);
		write_reg(REG_HEIGHT, 64'd4);
		write_reg(REG_FORMAT, 64'd0);
		repeat (6) send_random_pixel();
		drain();
		write_reg(REG_WIDTH, 64'd2);
		write_reg(REG_HEIGHT, 64'd1);
		repeat (3) send_random_pixel();
		drain();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_COEF0, {rand_fp32(), rand_fp32()});
			write_reg(REG_COEF1, {rand_fp32(), rand_fp32()});
			write_reg(REG_COEF2, {rand_fp32(), rand_fp32()});
			write_reg(REG_COEF3, {rand_fp32(), rand_fp32()});
			write_reg(REG_CHANNELS, 64'($urandom_range(0, 7)));
			write_reg(REG_WIDTH, rand_dim());
			write_reg(REG_HEIGHT, rand_dim());
			write_reg(REG_FORMAT, 64'(ph % 4));
			no_idle = (ph == 4);
			repeat (52) send_random_pixel();
			drain();
			no_idle = 1'b0;
		end
	endtask

	task automatic test_output_stall();
		write_reg(REG_CHANNELS, 64'd4);
		write_reg(REG_WIDTH, 64'd4);
		write_reg(REG_HEIGHT, 64'd3);
		write_reg(REG_FORMAT, 64'd1);
		pop_hold = 300;
		no_idle = 1'b1;
		repeat (30) send_random_pixel();
		no_idle = 1'b0;
		drain();
	endtask

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		sample_0 = 8'd0;
		sample_1 = 8'd0;
		sample_2 = 8'd0;
		sample_3 = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = 4'd0;
		cfg_data = 64'd0;
		for (int i = 0; i < 4; i++)
			coef_m[i] = COEF_RESET;
		chans_m = 3'd3;
		width_m = 13'd640;
		height_m = 13'd640;
		format_m = 2'd0;
		col_m = 32'd0;
		row_m = 32'd0;
		mismatches = 0;
		results_seen = 0;
		pixels_sent = 0;
		regs_written = 0;
		pop_hold = 0;
		pop_wait = 0;
		no_idle = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_fp32_specials();
		test_half_planar();
		test_size_clamps();
		test_shrunk_frame();
		test_output_stall();
		test_random_phases();
		drain();
		repeat (40) @(posedge clk);
		mismatches += pending_results.size();
		$display("%0d pixels, %0d results, %0d register writes: fp32/half, HWC/CHW, clamps",
			pixels_sent, results_seen, regs_written);
		$display("specials: NaN, inf, overflow, subnormal, half clamp, shrunk frame, stall");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
